/* src/hsiq_pkg.sv */
// Package for the chained hash set: default sizes and the operation codes.
// No dependencies.
`default_nettype none
package hsiq_pkg;
  localparam int unsigned BUCKETS_DEF = 1024;
  localparam int unsigned NODES_DEF   = 4096;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_NODE,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic present;
    logic status;
  } result_t;
endpackage
`default_nettype wire

/* src/hash_set_insert_query.sv */
// Top level of the chained hash set with insert and query.
// Depends on hsiq_pkg, hsiq_front and hsiq_back.
//
// Requests enter a two-entry queue and are served one at a time by a chain
// walker. After reset the walker zeroes every bucket head before it takes
// the first request. A request reads its bucket head and then, for every
// chain node compared, reads the node through the registered read of the
// node memory and compares its key; the walk stops at the first match. A
// bucket count that is not a power of two adds the restoring remainder
// before the head read. A result waits in an output register, so the walker
// takes the next request meanwhile; only a second finished result holds it
// in its done state until the first one is taken.
`default_nettype none
module hash_set_insert_query #(
  parameter int unsigned BUCKETS = hsiq_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = hsiq_pkg::NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // key[31:0]
  input  wire logic        in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata  // present, status, zero fill
);
  logic        q_valid, q_pop;
  logic [32:0] q_data;
  hsiq_pkg::result_t res;

  hsiq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data({in_tdata, in_tuser}), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data));

  hsiq_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_res(res));

  assign out_tdata = {6'b0, res.status, res.present};
endmodule
`default_nettype wire

/* src/hsiq_ram.sv */
// Generic RAM with one write port, one read port and registered read.
// No dependencies.
`default_nettype none
module hsiq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/hsiq_front.sv */
// Front end: takes requests and holds them in a two-entry queue for the back end.
// Depends on nothing but its ports.
`default_nettype none
module hsiq_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [32:0] in_data,
  output logic             q_valid,
  input  wire logic        q_pop,
  output logic      [32:0] q_data
);
  logic [32:0] mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

/* src/hsiq_back.sv */
// Back end: walks a bucket chain in node memory and inserts at the head.
// Depends on hsiq_pkg and hsiq_ram.
`default_nettype none
module hsiq_back #(
  parameter int unsigned BUCKETS = hsiq_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = hsiq_pkg::NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire logic [32:0] q_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output hsiq_pkg::result_t out_res
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned BD = (BUCKETS > 1) ? BUCKETS : 2;
  localparam int unsigned ND = (NODES > 1) ? NODES : 2;
  // A power-of-two bucket count hashes by masking the low key bits.
  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  // 2^32 mod BUCKETS: the offset between a negative key and its raw bits.
  localparam logic [47:0] WRAP = 48'((64'd1 << 32) % 64'(BUCKETS));

  hsiq_pkg::state_t state_r, state_nxt;
  logic [31:0] key_r;
  logic        func_r;
  logic [BW-1:0] bkt_r, bkt_nxt, bkt_c, bkt_hash, clr_r;
  logic [LW-1:0] link_r, used_r, head_link_r;
  logic          clr_done_r, clearing;
  logic          found_r, ovalid_r;
  hsiq_pkg::result_t res_r;
  logic [31:0]   hr_r;
  logic [2:0]    hcnt_r;
  logic [47:0]   hrem, hdiv, hfix;
  logic [4:0]    hsh;
  logic [LW-1:0] head_rd, link_rd;
  logic [31:0]   key_rd;
  logic          head_we, done_go, ins_ok, pool_full;

  // Bucket is the floored remainder; for powers of two that is the low bits.
  assign bkt_c = BW'(q_data[32:1] & 32'(BUCKETS - 1));

  // Other counts: restoring remainder of the raw key bits, four bit positions
  // per cycle from the top bit down, then the offset for negative keys.
  always_comb begin
    hrem = {16'b0, hr_r};
    hdiv = '0;
    hsh  = '0;
    for (int i = 0; i < 4; i++) begin
      hsh  = 5'd31 - {hcnt_r, 2'b00} - 5'(i);
      hdiv = 48'(BUCKETS) << hsh;
      if (hrem >= hdiv) hrem = hrem - hdiv;
    end
    if (!key_r[31]) hfix = hrem;
    else if (hrem >= WRAP) hfix = hrem - WRAP;
    else hfix = hrem + 48'(BUCKETS) - WRAP;
    bkt_hash = BW'(hfix);
  end

  always_comb begin
    bkt_nxt = bkt_r;
    if (state_r == hsiq_pkg::ST_IDLE && q_pop && POW2) bkt_nxt = bkt_c;
    if (state_r == hsiq_pkg::ST_HASH && hcnt_r == 3'd7) bkt_nxt = bkt_hash;
  end

  assign clearing  = !clr_done_r;
  assign done_go   = (state_r == hsiq_pkg::ST_DONE) && (!ovalid_r || out_tready);
  assign ins_ok    = (func_r == hsiq_pkg::FUNC_INSERT) && !found_r;
  assign pool_full = (used_r == LW'(NODES));
  assign head_we   = done_go && ins_ok && !pool_full;

  hsiq_ram #(.WIDTH(LW), .DEPTH(BD)) u_heads (
    .clk(clk), .we(head_we || clearing), .waddr(clearing ? clr_r : bkt_r),
    .wdata(clearing ? '0 : LW'(used_r + 1'b1)),
    .raddr(bkt_nxt), .rdata(head_rd));
  hsiq_ram #(.WIDTH(32), .DEPTH(ND)) u_keys (
    .clk(clk), .we(head_we), .waddr(NW'(used_r)), .wdata(key_r),
    .raddr(NW'(link_r - 1'b1)), .rdata(key_rd));
  hsiq_ram #(.WIDTH(LW), .DEPTH(ND)) u_links (
    .clk(clk), .we(head_we), .waddr(NW'(used_r)), .wdata(head_link_r),
    .raddr(NW'(link_r - 1'b1)), .rdata(link_rd));

  assign q_pop      = (state_r == hsiq_pkg::ST_IDLE) && q_valid && !clearing;
  assign out_tvalid = ovalid_r;
  assign out_res    = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsiq_pkg::ST_IDLE:
        if (q_pop) state_nxt = POW2 ? hsiq_pkg::ST_HEAD : hsiq_pkg::ST_HASH;
      hsiq_pkg::ST_HASH: if (hcnt_r == 3'd7) state_nxt = hsiq_pkg::ST_HEAD;
      hsiq_pkg::ST_HEAD: state_nxt = hsiq_pkg::ST_NODE;
      hsiq_pkg::ST_NODE:
        state_nxt = (link_r == '0) ? hsiq_pkg::ST_DONE : hsiq_pkg::ST_CMP;
      hsiq_pkg::ST_CMP:
        state_nxt = (key_rd == key_r || link_rd == '0) ? hsiq_pkg::ST_DONE
                                                        : hsiq_pkg::ST_NODE;
      hsiq_pkg::ST_DONE: if (done_go) state_nxt = hsiq_pkg::ST_IDLE;
      default: state_nxt = hsiq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsiq_pkg::ST_IDLE;
      used_r <= '0; ovalid_r <= 1'b0; res_r <= '0; found_r <= 1'b0;
      clr_r <= '0; clr_done_r <= 1'b0; bkt_r <= '0;
    end else begin
      state_r <= state_nxt;
      bkt_r   <= bkt_nxt;
      // Bucket heads are zeroed one per cycle after reset.
      if (clearing) begin
        clr_r <= BW'(clr_r + 1'b1);
        if (clr_r == BW'(BD - 1)) clr_done_r <= 1'b1;
      end
      if (done_go) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        hsiq_pkg::ST_IDLE: if (q_pop) begin
          func_r <= q_data[0]; key_r <= q_data[32:1]; hr_r <= q_data[32:1];
          hcnt_r <= '0; found_r <= 1'b0;
        end
        hsiq_pkg::ST_HASH: begin
          hr_r   <= hrem[31:0];
          hcnt_r <= hcnt_r + 3'd1;
        end
        hsiq_pkg::ST_HEAD: begin
          link_r      <= head_rd;
          head_link_r <= head_rd;
        end
        hsiq_pkg::ST_NODE: ;
        hsiq_pkg::ST_CMP: begin
          if (key_rd == key_r) found_r <= 1'b1;
          else link_r <= link_rd;
        end
        hsiq_pkg::ST_DONE: if (done_go) begin
          res_r <= '{present: found_r, status: ins_ok && pool_full};
          if (head_we) used_r <= LW'(used_r + 1'b1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/hash_set_insert_query_chk.sv */
// Port checker for the hash set, bound to the top level.
// Depends on hash_set_insert_query.
`default_nettype none
module hash_set_insert_query_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("present and dropped together");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0)
    else $error("fill bits set");
endmodule
bind hash_set_insert_query hash_set_insert_query_chk u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire

/* tb/hash_set_insert_query_tb.sv */
// Testbench for the chained hash set: directed and random insert and query
// requests checked against a predictor of the set. Depends on hsiq_pkg and hash_set_insert_query.
`timescale 1ns / 1ps
module hash_set_insert_query_tb;

  localparam int unsigned NB = hsiq_pkg::BUCKETS_DEF;
  localparam int unsigned NN = hsiq_pkg::NODES_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // Predicted set contents: keys stored in insertion order, plus bucket chains.
  logic [31:0] pool_keys [NN];
  int          pool_link [NN];
  int          heads [NB];
  int          pool_used = 0;
  hsiq_pkg::result_t expected_results [$];
  int          errors = 0;
  bit          drain_idle = 1'b0;
  bit          hold_idle = 1'b0;
  logic [31:0] key_hist [$];

  hash_set_insert_query dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floored modulo of a signed key: for a power-of-two count the low bits.
  function automatic int bucket_for(logic [31:0] key);
    longint k;
    longint r;
    k = longint'(signed'(key));
    r = k % longint'(NB);
    if (r < 0) r += NB;
    return int'(r);
  endfunction

  // Walks the predicted chain and updates the set like the block would.
  function automatic hsiq_pkg::result_t predict_set_op(logic func, logic [31:0] key);
    hsiq_pkg::result_t r;
    int b;
    int link;
    b = bucket_for(key);
    link = heads[b];
    r.present = 1'b0;
    r.status = 1'b0;
    while (link != 0) begin
      if (pool_keys[link-1] == key) begin
        r.present = 1'b1;
        break;
      end
      link = pool_link[link-1];
    end
    if (func == hsiq_pkg::FUNC_INSERT && !r.present) begin
      if (pool_used < NN) begin
        pool_keys[pool_used] = key;
        pool_link[pool_used] = heads[b];
        heads[b] = pool_used + 1;
        pool_used++;
      end else begin
        r.status = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Sends one request, first idling while a random draw falls under 21 in 100, unless idling is off.
  // Valid stays high after the handshake until the next idle cycle or wait.
  task automatic send_request(logic func, logic [31:0] key);
    while (!hold_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= key;
    expected_results.push_back(predict_set_op(func, key));
    key_hist.push_back(key);
    do @(posedge clk); while (!in_tready);
  endtask

  // Result side: random stall, then compare each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          hsiq_pkg::result_t e;
          e = expected_results.pop_front();
          if (out_tdata[0] !== e.present)
            report_mismatch($sformatf("present %b want %b", out_tdata[0], e.present));
          if (out_tdata[1] !== e.status)
            report_mismatch($sformatf("status %b want %b", out_tdata[1], e.status));
        end
      end
      out_tready <= drain_idle ? 1'b1 : ($urandom_range(99) >= 21);
    end
  end

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(hsiq_pkg::FUNC_QUERY, 32'h0000_0000);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h0000_0000);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h0000_0000);
    send_request(hsiq_pkg::FUNC_QUERY, 32'h0000_0000);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h8000_0000);
    send_request(hsiq_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_request(hsiq_pkg::FUNC_QUERY, 32'h7FFF_FFFF);
    send_request(hsiq_pkg::FUNC_QUERY, 32'h8000_0000);
    send_request(hsiq_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
    // Negative and positive keys sharing one bucket build a chain.
    send_request(hsiq_pkg::FUNC_INSERT, 32'hFFFF_FC05);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h0000_0405);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h0000_0005);
    send_request(hsiq_pkg::FUNC_QUERY, 32'hFFFF_FC05);
    send_request(hsiq_pkg::FUNC_QUERY, 32'h0000_0805);
    send_request(hsiq_pkg::FUNC_INSERT, 32'h0000_0405);
  endtask

  // Inserts and queries of fresh and stored keys, with a pause until the block drains.
  task automatic test_random_mix(int count);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: k = $urandom();
        1: k = key_hist[$urandom_range(key_hist.size()-1)];
        2: k = ($urandom_range(7) << 10) | $urandom_range(3);  // long chains
        default: k = {$urandom_range(1) ? 22'h3FFFFF : 22'h0, 10'($urandom())};
      endcase
      send_request(logic'($urandom_range(1)), k);
      if (i == count / 2) wait_results();
    end
  endtask

  // Alternates fresh keys with keys known to be stored.
  task automatic test_stored_lookups();
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0)
        send_request(logic'($urandom_range(1)), $urandom());
      else
        send_request(logic'($urandom_range(1)),
                     pool_keys[$urandom_range(pool_used-1)]);
    end
  endtask

  initial begin
    for (int i = 0; i < NB; i++) heads[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(450);
    drain_idle = 1'b1;
    hold_idle = 1'b1;
    test_random_mix(200);
    drain_idle = 1'b0;
    hold_idle = 1'b0;
    test_random_mix(450);
    test_stored_lookups();
    wait_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
src/hsiq_pkg.sv
src/hsiq_ram.sv
src/hsiq_front.sv
src/hsiq_back.sv
src/hash_set_insert_query.sv
src/hash_set_insert_query_chk.sv
tb/hash_set_insert_query_tb.sv
